// File: hdl/puok_pkg.sv
// Package for the prioritised UTC offset keeper: operation, source and
// status codes, field widths and the reset value of the UTC limit.
// No dependencies.
package puok_pkg;

    // Field widths
    localparam int unsigned OpW      = 2;
    localparam int unsigned SrcW     = 2;
    localparam int unsigned TimeW    = 64;
    localparam int unsigned UtcW     = 63;
    localparam int unsigned StatusW  = 3;
    localparam int unsigned SDataW   = 136;
    localparam int unsigned MDataW   = 200;
    localparam int unsigned ApbDataW = 64;
    localparam int unsigned ApbAddrW = 4;

    // Operation codes
    localparam logic [OpW-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OpW-1:0] OP_SUBMIT   = 2'd1;
    localparam logic [OpW-1:0] OP_CONVERT  = 2'd2;
    localparam logic [OpW-1:0] OP_SNAPSHOT = 2'd3;

    // Source codes, in rising priority
    localparam logic [SrcW-1:0] SRC_NONE    = 2'd0;
    localparam logic [SrcW-1:0] SRC_GPS     = 2'd1;
    localparam logic [SrcW-1:0] SRC_CLOUD   = 2'd2;
    localparam logic [SrcW-1:0] SRC_INVALID = 2'd3;

    // Status codes
    localparam logic [StatusW-1:0] ST_OK       = 3'd0;
    localparam logic [StatusW-1:0] ST_INVALID  = 3'd1;
    localparam logic [StatusW-1:0] ST_REJECTED = 3'd2;
    localparam logic [StatusW-1:0] ST_NO_TIME  = 3'd3;
    localparam logic [StatusW-1:0] ST_RANGE    = 3'd4;

    // Register map: index of the UTC limit register
    localparam logic [0:0] REG_UTC_LIMIT = 1'b0;

    // End of year 9999 in milliseconds
    localparam logic [UtcW-1:0] UTC_LIMIT_RESET = 63'd253402300799999;

    // One captured input word
    typedef struct packed {
        logic [OpW-1:0]   operation;
        logic [SrcW-1:0]  sample_source;
        logic [TimeW-1:0] sample_utc_ms;
        logic [TimeW-1:0] mono_ms;
    } in_word_t;

endpackage

// File: hdl/prioritized_utc_offset_keeper.sv
// Top level of the prioritised UTC offset keeper: input register, the
// submit/convert/snapshot logic with the held offset, and the result register.
// Depends on puok_pkg.
//
// The block holds one UTC-minus-monotonic offset with its source (none below
// gps below cloud) and the monotonic time of the sample that set it. Each
// input word gives exactly one result word. A word accepted at one edge is
// loaded into the result register at the next edge when that register is
// free, and m_tvalid rises with that load: while the word sits in the input
// register, the checks, one 64-bit add or subtract and the limit compares
// run combinationally into the result register, where the held state is
// updated at the same edge. A stalled result holds the word in the input
// register and drops s_tready once both registers are full.
// A new word is accepted every cycle while the result side keeps up. The
// UTC limit sits at byte address 0 of the 64-bit APB port (bits 62:0) and
// must be written only while the block is idle.
module prioritized_utc_offset_keeper (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] sample_source, [65:2] sample_utc_ms, [129:66] mono_ms, rest zero
    input  logic [puok_pkg::SDataW-1:0]       s_tdata,
    // [1:0] operation
    input  logic [puok_pkg::OpW-1:0]          s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [62:0] utc_out_ms, [64:63] time_source, [65] time_valid,
    // [129:66] offset_out_ms, [192:130] sample_time_out_ms, rest zero
    output logic [puok_pkg::MDataW-1:0]       m_tdata,
    // [2:0] status
    output logic [puok_pkg::StatusW-1:0]      m_tuser,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [puok_pkg::ApbAddrW-1:0]     paddr,
    input  logic [puok_pkg::ApbDataW-1:0]     pwdata,
    output logic [puok_pkg::ApbDataW-1:0]     prdata,
    output logic                              pready
);

    logic                              in_valid_reg;
    puok_pkg::in_word_t                in_word_reg;
    logic                              out_valid_reg;
    logic [puok_pkg::MDataW-1:0]       out_data_reg;
    logic [puok_pkg::StatusW-1:0]      out_status_reg;
    logic [puok_pkg::UtcW-1:0]         utc_limit_reg;
    logic [puok_pkg::SrcW-1:0]         held_source_reg;
    logic [puok_pkg::TimeW-1:0]        held_offset_reg;
    logic [puok_pkg::UtcW-1:0]         held_sample_time_reg;

    logic [puok_pkg::SrcW-1:0]         held_source_next;
    logic [puok_pkg::TimeW-1:0]        held_offset_next;
    logic [puok_pkg::UtcW-1:0]         held_sample_time_next;
    logic [puok_pkg::StatusW-1:0]      status_next;
    logic [puok_pkg::UtcW-1:0]         utc_out_next;
    logic [puok_pkg::MDataW-1:0]       out_data_next;

    logic                              advance;
    logic                              cfg_write;
    logic                              bad_submit;
    logic                              refused;
    logic [puok_pkg::TimeW-1:0]        diff;
    logic [puok_pkg::TimeW-1:0]        sum;

    // Handshake: the input register moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // APB: always ready, one 64-bit register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[3] == puok_pkg::REG_UTC_LIMIT);
    assign prdata    = (paddr[3] == puok_pkg::REG_UTC_LIMIT)
                       ? {1'b0, utc_limit_reg} : '0;

    // Arithmetic on the captured word
    assign diff = in_word_reg.sample_utc_ms - in_word_reg.mono_ms;
    assign sum  = in_word_reg.mono_ms + held_offset_reg;

    // Submit checks: bad source or range, then priority and age
    assign bad_submit = ((in_word_reg.sample_source != puok_pkg::SRC_GPS)
                         && (in_word_reg.sample_source != puok_pkg::SRC_CLOUD))
                        || in_word_reg.sample_utc_ms[63]
                        || (in_word_reg.sample_utc_ms[62:0] > utc_limit_reg)
                        || in_word_reg.mono_ms[63];
    assign refused    = (held_source_reg > in_word_reg.sample_source)
                        || ((held_source_reg == in_word_reg.sample_source)
                            && (held_sample_time_reg > in_word_reg.mono_ms[62:0]));

    // Work out the status, the converted time and the new held state
    always_comb begin
        held_source_next      = held_source_reg;
        held_offset_next      = held_offset_reg;
        held_sample_time_next = held_sample_time_reg;
        status_next           = puok_pkg::ST_OK;
        utc_out_next          = '0;
        unique case (in_word_reg.operation)
            puok_pkg::OP_CLEAR: begin
                held_source_next      = puok_pkg::SRC_NONE;
                held_offset_next      = '0;
                held_sample_time_next = '0;
            end
            puok_pkg::OP_SUBMIT: begin
                priority if (bad_submit) begin
                    status_next = puok_pkg::ST_INVALID;
                end else if (refused) begin
                    status_next = puok_pkg::ST_REJECTED;
                end else begin
                    held_source_next      = in_word_reg.sample_source;
                    held_offset_next      = diff;
                    held_sample_time_next = in_word_reg.mono_ms[62:0];
                end
            end
            puok_pkg::OP_CONVERT: begin
                // A positive offset overflowing the add also sets the sign bit
                priority if (in_word_reg.mono_ms[63]) begin
                    status_next = puok_pkg::ST_INVALID;
                end else if (held_source_reg == puok_pkg::SRC_NONE) begin
                    status_next = puok_pkg::ST_NO_TIME;
                end else if (sum[63] || (sum[62:0] > utc_limit_reg)) begin
                    status_next = puok_pkg::ST_RANGE;
                end else begin
                    utc_out_next = sum[62:0];
                end
            end
            puok_pkg::OP_SNAPSHOT: begin
            end
            default: begin
            end
        endcase
    end

    // Pack the result word, reporting state after the operation
    assign out_data_next = {7'd0,
                            held_sample_time_next,
                            held_offset_next,
                            (held_source_next != puok_pkg::SRC_NONE),
                            held_source_next,
                            utc_out_next};

    // Control state, configuration and held state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            utc_limit_reg        <= puok_pkg::UTC_LIMIT_RESET;
            held_source_reg      <= puok_pkg::SRC_NONE;
            held_offset_reg      <= '0;
            held_sample_time_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg        <= 1'b1;
                held_source_reg      <= held_source_next;
                held_offset_reg      <= held_offset_next;
                held_sample_time_reg <= held_sample_time_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                utc_limit_reg <= pwdata[62:0];
            end
        end
    end

    // Payload registers: capture input word, hold result word
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg.operation     <= s_tuser;
            in_word_reg.sample_source <= s_tdata[1:0];
            in_word_reg.sample_utc_ms <= s_tdata[65:2];
            in_word_reg.mono_ms       <= s_tdata[129:66];
        end
        if (advance) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= status_next;
        end
    end

    // A held source is never the invalid code
    a_source_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        held_source_reg != puok_pkg::SRC_INVALID)
        else $error("held source took the invalid code");

    // Any failing status carries a zero converted time
    a_err_zero_utc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != puok_pkg::ST_OK)) |-> (m_tdata[62:0] == '0))
        else $error("converted time not zero on error");

    // Reported valid flag follows the reported source
    a_valid_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[65] == (m_tdata[64:63] != puok_pkg::SRC_NONE)))
        else $error("time_valid disagrees with time_source");

    // Held state changes only when a word passes into the result register
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(advance))
        |-> ($stable(held_source_reg) && $stable(held_offset_reg)
             && $stable(held_sample_time_reg)))
        else $error("held state changed without an item");

    // An accepted submit reports the source it stored
    a_submit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_word_reg.operation == puok_pkg::OP_SUBMIT)
         && !bad_submit && !refused)
        |=> (held_source_reg == $past(in_word_reg.sample_source)))
        else $error("accepted submit did not store its source");

endmodule
